FILE: hw/rtl/dll_pkg.sv
`timescale 1ns / 1ps

package dll_pkg;

    localparam int NODES  = 64;
    localparam int IDX_W  = 6;
    localparam int LINK_W = 7;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

    typedef enum logic [1:0] {
        OP_INS_HEAD = 2'd0,
        OP_INS_TAIL = 2'd1,
        OP_REM_HEAD = 2'd2,
        OP_UNLINK   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] node_index;
    } item_t;

    typedef struct packed {
        logic [LINK_W-1:0] returned_node;
        logic [LINK_W-1:0] head_node;
        logic [LINK_W-1:0] tail_node;
        logic [LINK_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] node;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic idle;
        logic exec_go;
    } back_status_t;

    function automatic logic is_slot(input logic [LINK_W-1:0] x);
        return x < NULL_LINK;
    endfunction

endpackage

FILE: hw/rtl/dll_front.sv
`timescale 1ns / 1ps

module dll_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dll_pkg::item_t s_item,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output dll_pkg::cmd_t  cmd
);

    logic          front_valid_reg;
    logic          front_valid_next;
    dll_pkg::cmd_t cmd_reg;
    dll_pkg::cmd_t cmd_next;
    logic          take;

    assign s_ready   = !front_valid_reg || cmd_ready;
    assign take      = s_valid && s_ready;
    assign cmd_valid = front_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.op   = dll_pkg::op_t'(s_item.opcode);
        cmd_next.node = s_item.node_index;
        if (take) begin
            front_valid_next = 1'b1;
        end else if (cmd_ready) begin
            front_valid_next = 1'b0;
        end else begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: hw/rtl/dll_fifo.sv
`timescale 1ns / 1ps

module dll_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dll_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output dll_pkg::cmd_t out_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dll_pkg::cmd_t    slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hw/rtl/dll_back.sv
`timescale 1ns / 1ps

module dll_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dll_pkg::cmd_t         in_cmd,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dll_pkg::result_t      m_result,
    output dll_pkg::back_status_t status
);

    localparam int IW = dll_pkg::IDX_W;
    localparam int LW = dll_pkg::LINK_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_WR2  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [LW-1:0] next_mem [dll_pkg::NODES];
    logic [LW-1:0] prev_mem [dll_pkg::NODES];
    logic [LW-1:0] nx_rd_reg;
    logic [LW-1:0] pv_rd_reg;
    logic [IW-1:0] rd_addr;

    dll_pkg::cmd_t cmd_reg;

    logic [LW-1:0] head_reg;
    logic [LW-1:0] head_next;
    logic [LW-1:0] tail_reg;
    logic [LW-1:0] tail_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;

    logic [LW-1:0] head_step;
    logic [LW-1:0] tail_step;
    logic [LW-1:0] len_step;
    logic [LW-1:0] ret_step;
    logic [LW-1:0] node_w;
    logic [LW-1:0] grown;
    logic [LW-1:0] shrunk;
    logic          list_empty;

    dll_pkg::link_wr_t nx_w1;
    dll_pkg::link_wr_t pv_w1;
    dll_pkg::link_wr_t nx_w2;
    dll_pkg::link_wr_t pv_w2;
    dll_pkg::link_wr_t nx_w2_reg;
    dll_pkg::link_wr_t pv_w2_reg;
    dll_pkg::link_wr_t nx_wr;
    dll_pkg::link_wr_t pv_wr;

    logic             out_valid_reg;
    logic             out_valid_next;
    dll_pkg::result_t out_data_reg;
    dll_pkg::result_t out_data_next;

    logic pop;
    logic exec_go;

    assign in_ready = state_reg == ST_IDLE;
    assign pop      = in_valid && in_ready;
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    assign rd_addr  = (in_cmd.op == dll_pkg::OP_REM_HEAD) ? head_reg[IW-1:0] : in_cmd.node;

    assign m_valid        = out_valid_reg;
    assign m_result       = out_data_reg;
    assign status.idle    = state_reg == ST_IDLE;
    assign status.exec_go = exec_go;

    assign node_w     = {1'b0, cmd_reg.node};
    assign list_empty = len_reg == '0;
    assign grown      = (len_reg < dll_pkg::NULL_LINK) ? len_reg + LW'(1) : len_reg;
    assign shrunk     = list_empty ? len_reg : len_reg - LW'(1);

    // The first write of each table happens as the step executes, the second in the following cycle,
    // so that where both hit the same slot the later one of the sequence wins.
    always_comb begin
        head_step = head_reg;
        tail_step = tail_reg;
        len_step  = len_reg;
        ret_step  = dll_pkg::NULL_LINK;
        nx_w1     = '0;
        pv_w1     = '0;
        nx_w2     = '0;
        pv_w2     = '0;
        case (cmd_reg.op)
            dll_pkg::OP_INS_HEAD: begin
                nx_w1     = '{en: 1'b1, addr: cmd_reg.node, data: head_reg};
                pv_w1     = '{en: 1'b1, addr: cmd_reg.node, data: dll_pkg::NULL_LINK};
                pv_w2     = '{en: !list_empty && dll_pkg::is_slot(head_reg),
                              addr: head_reg[IW-1:0], data: node_w};
                head_step = node_w;
                if (list_empty) begin
                    tail_step = node_w;
                end
                len_step  = grown;
                ret_step  = node_w;
            end
            dll_pkg::OP_INS_TAIL: begin
                pv_w1     = '{en: 1'b1, addr: cmd_reg.node, data: tail_reg};
                nx_w1     = '{en: 1'b1, addr: cmd_reg.node, data: dll_pkg::NULL_LINK};
                nx_w2     = '{en: !list_empty && dll_pkg::is_slot(tail_reg),
                              addr: tail_reg[IW-1:0], data: node_w};
                tail_step = node_w;
                if (list_empty) begin
                    head_step = node_w;
                end
                len_step  = grown;
                ret_step  = node_w;
            end
            dll_pkg::OP_REM_HEAD: begin
                if (!list_empty && dll_pkg::is_slot(head_reg)) begin
                    head_step = nx_rd_reg;
                    if (!dll_pkg::is_slot(nx_rd_reg)) begin
                        tail_step = dll_pkg::NULL_LINK;
                    end
                    pv_w1    = '{en: dll_pkg::is_slot(nx_rd_reg), addr: nx_rd_reg[IW-1:0],
                                 data: dll_pkg::NULL_LINK};
                    nx_w1    = '{en: 1'b1, addr: head_reg[IW-1:0], data: dll_pkg::NULL_LINK};
                    pv_w2    = '{en: 1'b1, addr: head_reg[IW-1:0], data: dll_pkg::NULL_LINK};
                    len_step = shrunk;
                    ret_step = head_reg;
                end
            end
            dll_pkg::OP_UNLINK: begin
                if (node_w == head_reg) begin
                    head_step = nx_rd_reg;
                end
                if (node_w == tail_reg) begin
                    tail_step = pv_rd_reg;
                end
                nx_w1    = '{en: dll_pkg::is_slot(pv_rd_reg), addr: pv_rd_reg[IW-1:0],
                             data: nx_rd_reg};
                pv_w1    = '{en: dll_pkg::is_slot(nx_rd_reg), addr: nx_rd_reg[IW-1:0],
                             data: pv_rd_reg};
                nx_w2    = '{en: 1'b1, addr: cmd_reg.node, data: dll_pkg::NULL_LINK};
                pv_w2    = '{en: 1'b1, addr: cmd_reg.node, data: dll_pkg::NULL_LINK};
                len_step = shrunk;
                ret_step = node_w;
            end
            default: begin
                ret_step = dll_pkg::NULL_LINK;
            end
        endcase
    end

    always_comb begin
        nx_wr = '0;
        pv_wr = '0;
        if (exec_go) begin
            nx_wr = nx_w1;
            pv_wr = pv_w1;
        end else if (state_reg == ST_WR2) begin
            nx_wr = nx_w2_reg;
            pv_wr = pv_w2_reg;
        end
    end

    always_comb begin
        head_next = exec_go ? head_step : head_reg;
        tail_next = exec_go ? tail_step : tail_reg;
        len_next  = exec_go ? len_step : len_reg;

        out_data_next.returned_node = ret_step;
        out_data_next.head_node     = head_step;
        out_data_next.tail_node     = tail_step;
        out_data_next.entry_count   = len_step;

        if (exec_go) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_WR2;
                end
            end
            ST_WR2: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= dll_pkg::NULL_LINK;
            tail_reg      <= dll_pkg::NULL_LINK;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= in_cmd;
        end
        if (exec_go) begin
            nx_w2_reg    <= nx_w2;
            pv_w2_reg    <= pv_w2;
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            nx_rd_reg <= next_mem[rd_addr];
            pv_rd_reg <= prev_mem[rd_addr];
        end
        if (nx_wr.en) begin
            next_mem[nx_wr.addr] <= nx_wr.data;
        end
        if (pv_wr.en) begin
            prev_mem[pv_wr.addr] <= pv_wr.data;
        end
    end

endmodule

FILE: hw/rtl/doubly_linked_list_manager_core.sv
// Keeps one doubly linked list over 64 node slots; the value 64 stands for null.
// Input words arrive on s_valid/s_ready/s_item, each carrying an opcode (insert at
// head, insert at tail, remove head, unlink a given node) and a node index.
// Every input word yields exactly one result word on m_valid/m_ready/m_result: the
// node returned, and the head, tail and entry count after the operation.
// An input register and a small command queue sit ahead of the execution unit, so
// the sender can keep posting words while the unit is busy.
// The unit handles one word at a time: queue pop with the link reads, execute, then the
// second link write, before it takes the next word. The separate second write step is
// set by the single write port of each link memory.
// A stalled receiver holds the result in the output register; the unit waits in its
// execute step and the queue fills, after which s_ready falls.
// Synchronous reset (aresetn low) empties the list and the queue. The link memories
// are not cleared; they are always written before they are read on a sound list.
`timescale 1ns / 1ps

module doubly_linked_list_manager_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dll_pkg::item_t   s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output dll_pkg::result_t m_result
);

    logic                  f_valid;
    logic                  f_ready;
    dll_pkg::cmd_t         f_cmd;
    logic                  q_valid;
    logic                  q_ready;
    dll_pkg::cmd_t         q_cmd;
    dll_pkg::back_status_t bk_status;

    dll_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    dll_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    dll_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_cmd   (q_cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .status   (bk_status)
    );

`ifndef NO_ASSERTIONS
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(bk_status.exec_go))
        else $error("Result appeared without an executed step.");

    a_no_pop_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_status.exec_go |=> !(q_valid && q_ready))
        else $error("Queue popped while the second link write was pending.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.entry_count <= dll_pkg::NULL_LINK))
        else $error("Entry count exceeds the pool size.");
`endif

endmodule
